// ----- rtl/core/ssst_pkg.sv -----
`timescale 1ns / 1ps

package ssst_pkg;

  localparam int COORD_BITS_DEF = 16;

  localparam int AXES = 3;

  // Per-request flags carried alongside the wide products
  typedef struct packed {
    logic line;    // nearest point lies inside the segment span
    logic far_pt;  // endpoint distance exceeds the radius
    logic both_in; // both endpoints lie within the radius
  } ctl_t;

endpackage

// ----- rtl/core/segment_sphere_surface_test_core.sv -----
`timescale 1ns / 1ps

// Channel  | Ports                                         | Handshake
// ---------+-----------------------------------------------+----------------------------
// request  | start_x/y/z, end_x/y/z, center_x/y/z, radius | start && !busy accepts
// result   | hit                                           | done, one cycle, no backpressure
//
// Eight-stage pipeline: one request per cycle whenever rst is low.
// The wide squared-distance products are split into half-width partial products,
// which sets the depth: difference, product, sum, magnitude, partial product,
// recombine, accumulate, compare.
// rst is synchronous and clears the valid chain; busy is high only during reset.
// The result cannot be stalled, so no request is ever held off after reset.

module segment_sphere_surface_test_core
  import ssst_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] start_z,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] end_z,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic signed [COORD_BITS-1:0] center_z,
  input  logic        [COORD_BITS-1:0] radius,
  output logic                         done,
  output logic                         hit
);

  localparam int W   = COORD_BITS;
  localparam int D   = W + 1;
  localparam int P   = 2 * D;
  localparam int U   = P + 2;
  localparam int H   = U / 2;
  localparam int F   = 2 * U;
  localparam int LAT = 8;

  logic accept;
  logic [LAT:1] valid;

  logic signed [D-1:0] b [AXES];
  logic signed [D-1:0] p [AXES];
  logic signed [D-1:0] q [AXES];
  logic [W-1:0] r1;

  logic signed [P-1:0] bp [AXES];
  logic signed [P-1:0] bq [AXES];
  logic signed [P-1:0] pp [AXES];
  logic signed [P-1:0] qq [AXES];
  logic signed [P-1:0] bb [AXES];
  logic signed [P-1:0] cr_a [AXES];
  logic signed [P-1:0] cr_b [AXES];
  logic [2*W-1:0] rr2;

  logic signed [U-1:0] ds2;
  logic signed [U-1:0] de2;
  logic signed [U-1:0] b2;
  logic signed [U-1:0] dot1;
  logic signed [U-1:0] dot2;
  logic signed [U-1:0] k [AXES];
  logic [2*W-1:0] rr3;

  logic [U-1:0] kmag [AXES];
  logic [U-1:0] bmag;
  logic [U-1:0] r2w;
  logic use_s;
  logic use_e;
  ctl_t ctl4;
  ctl_t ctl5;
  ctl_t ctl6;
  ctl_t ctl7;

  logic [2*H-1:0] kll [AXES];
  logic [2*H-1:0] klh [AXES];
  logic [2*H-1:0] khh [AXES];
  logic [2*H-1:0] rll;
  logic [2*H-1:0] rlh;
  logic [2*H-1:0] rhl;
  logic [2*H-1:0] rhh;

  logic [F-1:0] ksq [AXES];
  logic [F-1:0] rb6;

  logic [F+1:0] k2;
  logic [F+1:0] rb7;

  assign busy   = rst;
  assign accept = start && !busy;
  assign done   = valid[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[LAT-1:1], accept};
    end
  end

  // stage 1: differences
  always_ff @(posedge clk) begin
    b[0] <= D'(end_x) - D'(start_x);
    b[1] <= D'(end_y) - D'(start_y);
    b[2] <= D'(end_z) - D'(start_z);
    p[0] <= D'(center_x) - D'(start_x);
    p[1] <= D'(center_y) - D'(start_y);
    p[2] <= D'(center_z) - D'(start_z);
    q[0] <= D'(center_x) - D'(end_x);
    q[1] <= D'(center_y) - D'(end_y);
    q[2] <= D'(center_z) - D'(end_z);
    r1   <= radius;
  end

  // stage 2: narrow products
  always_ff @(posedge clk) begin
    for (int i = 0; i < AXES; i++) begin
      bp[i] <= P'(b[i]) * P'(p[i]);
      bq[i] <= P'(b[i]) * P'(q[i]);
      pp[i] <= P'(p[i]) * P'(p[i]);
      qq[i] <= P'(q[i]) * P'(q[i]);
      bb[i] <= P'(b[i]) * P'(b[i]);
    end
    cr_a[0] <= P'(b[1]) * P'(p[2]);
    cr_b[0] <= P'(b[2]) * P'(p[1]);
    cr_a[1] <= P'(b[2]) * P'(p[0]);
    cr_b[1] <= P'(b[0]) * P'(p[2]);
    cr_a[2] <= P'(b[0]) * P'(p[1]);
    cr_b[2] <= P'(b[1]) * P'(p[0]);
    rr2 <= (2*W)'(r1) * (2*W)'(r1);
  end

  // stage 3: sums
  always_ff @(posedge clk) begin
    ds2  <= U'(pp[0]) + U'(pp[1]) + U'(pp[2]);
    de2  <= U'(qq[0]) + U'(qq[1]) + U'(qq[2]);
    b2   <= U'(bb[0]) + U'(bb[1]) + U'(bb[2]);
    dot1 <= U'(bp[0]) + U'(bp[1]) + U'(bp[2]);
    dot2 <= -(U'(bq[0]) + U'(bq[1]) + U'(bq[2]));
    for (int i = 0; i < AXES; i++) begin
      k[i] <= U'(cr_a[i]) - U'(cr_b[i]);
    end
    rr3 <= rr2;
  end

  // stage 4: compare against radius, take magnitudes
  always_comb begin
    use_s = dot1[U-1] || (b2 == '0);
    use_e = !use_s && dot2[U-1];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < AXES; i++) begin
      kmag[i] <= k[i][U-1] ? U'(-k[i]) : U'(k[i]);
    end
    bmag         <= U'(b2);
    r2w          <= U'(rr3);
    ctl4.line    <= !use_s && !use_e;
    ctl4.far_pt  <= use_s ? (U'(ds2) > U'(rr3)) : (U'(de2) > U'(rr3));
    ctl4.both_in <= (U'(ds2) <= U'(rr3)) && (U'(de2) <= U'(rr3));
  end

  // stage 5: half-width partial products
  always_ff @(posedge clk) begin
    for (int i = 0; i < AXES; i++) begin
      kll[i] <= (2*H)'(kmag[i][H-1:0]) * (2*H)'(kmag[i][H-1:0]);
      klh[i] <= (2*H)'(kmag[i][H-1:0]) * (2*H)'(kmag[i][U-1:H]);
      khh[i] <= (2*H)'(kmag[i][U-1:H]) * (2*H)'(kmag[i][U-1:H]);
    end
    rll  <= (2*H)'(r2w[H-1:0]) * (2*H)'(bmag[H-1:0]);
    rlh  <= (2*H)'(r2w[H-1:0]) * (2*H)'(bmag[U-1:H]);
    rhl  <= (2*H)'(r2w[U-1:H]) * (2*H)'(bmag[H-1:0]);
    rhh  <= (2*H)'(r2w[U-1:H]) * (2*H)'(bmag[U-1:H]);
    ctl5 <= ctl4;
  end

  // stage 6: recombine
  always_ff @(posedge clk) begin
    for (int i = 0; i < AXES; i++) begin
      ksq[i] <= (F'(khh[i]) << (2*H)) + (F'(klh[i]) << (H+1)) + F'(kll[i]);
    end
    rb6  <= (F'(rhh) << (2*H)) + (F'(rlh) << H) + (F'(rhl) << H) + F'(rll);
    ctl6 <= ctl5;
  end

  // stage 7: accumulate
  always_ff @(posedge clk) begin
    k2   <= (F+2)'(ksq[0]) + (F+2)'(ksq[1]) + (F+2)'(ksq[2]);
    rb7  <= (F+2)'(rb6);
    ctl7 <= ctl6;
  end

  // stage 8: decide
  always_ff @(posedge clk) begin
    if (ctl7.line) begin
      hit <= (k2 <= rb7) && !ctl7.both_in;
    end else begin
      hit <= !ctl7.far_pt && !ctl7.both_in;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("accepted request produced no result");

  a_no_spurious: assert property (@(posedge clk)
    done |-> $past(accept, LAT))
    else $error("result without a matching request");

  a_inside_no_hit: assert property (@(posedge clk) disable iff (rst)
    (valid[7] && ctl7.both_in) |=> !hit)
    else $error("hit reported with both endpoints inside the sphere");

endmodule

// ----- tb/tb_segment_sphere_surface_test_core.sv -----
`timescale 1ns / 1ps

module tb_segment_sphere_surface_test_core;
  import ssst_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int RANDOM_ITEMS = 435;

  typedef struct {
    logic signed [CW-1:0] sx, sy, sz;
    logic signed [CW-1:0] ex, ey, ez;
    logic signed [CW-1:0] cx, cy, cz;
    logic        [CW-1:0] r;
  } sphere_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  logic hit;

  sphere_req_t cur_req = '{default: '0};
  sphere_req_t pending[$];
  bit          hit_queue[$];
  bit          taken = 1'b0;
  int          idle_left = 0;
  int          burst_left = 0;
  int          mismatches = 0;
  bit          want;

  logic signed [CW-1:0] start_x, start_y, start_z;
  logic signed [CW-1:0] end_x, end_y, end_z;
  logic signed [CW-1:0] center_x, center_y, center_z;
  logic        [CW-1:0] radius;

  assign start_x  = cur_req.sx;
  assign start_y  = cur_req.sy;
  assign start_z  = cur_req.sz;
  assign end_x    = cur_req.ex;
  assign end_y    = cur_req.ey;
  assign end_z    = cur_req.ez;
  assign center_x = cur_req.cx;
  assign center_y = cur_req.cy;
  assign center_z = cur_req.cz;
  assign radius   = cur_req.r;

  segment_sphere_surface_test_core #(
    .COORD_BITS(CW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .start_x(start_x),
    .start_y(start_y),
    .start_z(start_z),
    .end_x(end_x),
    .end_y(end_y),
    .end_z(end_z),
    .center_x(center_x),
    .center_y(center_y),
    .center_z(center_z),
    .radius(radius),
    .done(done),
    .hit(hit)
  );

  always #4 clk = ~clk;

  function automatic bit surface_hit(sphere_req_t q);
    longint sx, sy, sz, ex, ey, ez, cx, cy, cz;
    longint bx, by, bz, px, py, pz, dx, dy, dz;
    longint dot_s, dot_e;
    longint unsigned r2, ds2, de2, b2;
    logic signed [127:0] kx, ky, kz, k2;
    logic [127:0] r2w, rb2;
    bit outside;
    sx = longint'(q.sx); sy = longint'(q.sy); sz = longint'(q.sz);
    ex = longint'(q.ex); ey = longint'(q.ey); ez = longint'(q.ez);
    cx = longint'(q.cx); cy = longint'(q.cy); cz = longint'(q.cz);
    r2 = longint'(q.r) * longint'(q.r);
    bx = ex - sx; by = ey - sy; bz = ez - sz;
    px = cx - sx; py = cy - sy; pz = cz - sz;
    dx = cx - ex; dy = cy - ey; dz = cz - ez;
    ds2 = px * px + py * py + pz * pz;
    de2 = dx * dx + dy * dy + dz * dz;
    b2 = bx * bx + by * by + bz * bz;
    dot_s = bx * px + by * py + bz * pz;
    dot_e = -(bx * dx) - by * dy - bz * dz;
    if (dot_s < 0 || b2 == 0) begin
      outside = ds2 > r2;
    end else if (dot_e < 0) begin
      outside = de2 > r2;
    end else begin
      kx = 128'(by) * 128'(pz) - 128'(bz) * 128'(py);
      ky = 128'(bz) * 128'(px) - 128'(bx) * 128'(pz);
      kz = 128'(bx) * 128'(py) - 128'(by) * 128'(px);
      k2 = kx * kx + ky * ky + kz * kz;
      r2w = 128'(r2);
      rb2 = r2w * 128'(b2);
      outside = k2 > rb2;
    end
    if (outside) return 1'b0;
    return !(ds2 <= r2 && de2 <= r2);
  endfunction

  function automatic sphere_req_t make_req(int sx, int sy, int sz, int ex, int ey, int ez,
                                           int cx, int cy, int cz, int r);
    sphere_req_t q;
    q.sx = CW'(sx); q.sy = CW'(sy); q.sz = CW'(sz);
    q.ex = CW'(ex); q.ey = CW'(ey); q.ez = CW'(ez);
    q.cx = CW'(cx); q.cy = CW'(cy); q.cz = CW'(cz);
    q.r = CW'(r);
    return q;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return any_coord();
    endcase
  endfunction

  function automatic sphere_req_t random_req();
    int c[3], a[3], b[3];
    int r, span, ax, bx, t0, t1;
    sphere_req_t q;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: begin
        q = make_req(any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
                     any_coord(), any_coord(), any_coord(), any_coord(),
                     $urandom_range(0, 65535));
      end
      5, 6, 7, 8, 9, 10, 11: begin
        r = $urandom_range(0, 400);
        span = r + $urandom_range(0, r + 20);
        for (int i = 0; i < 3; i++) begin
          c[i] = any_coord();
          a[i] = c[i] + spread(span);
          b[i] = c[i] + spread(span);
        end
        q = make_req(a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2], r);
      end
      12, 13, 14, 15: begin
        r = $urandom_range(0, 1000);
        ax = $urandom_range(0, 2);
        bx = (ax + 1 + $urandom_range(0, 1)) % 3;
        t0 = $urandom_range(0, 2000);
        t1 = $urandom_range(0, 1) ? 0 : $urandom_range(0, 2000);
        for (int i = 0; i < 3; i++) begin
          c[i] = any_coord();
          a[i] = c[i];
          b[i] = c[i];
        end
        if ($urandom_range(0, 1)) begin
          a[ax] -= r;
          b[ax] -= r;
        end else begin
          a[ax] += r;
          b[ax] += r;
        end
        a[bx] -= t0;
        b[bx] += t1;
        if ($urandom_range(0, 3) == 0) r = r + $urandom_range(0, 2) - 1;
        if (r < 0) r = 0;
        if ($urandom_range(0, 1)) begin
          q = make_req(a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2], r);
        end else begin
          q = make_req(b[0], b[1], b[2], a[0], a[1], a[2], c[0], c[1], c[2], r);
        end
      end
      default: begin
        case ($urandom_range(0, 4))
          0: r = 0;
          1: r = 65535;
          2: r = 32768;
          default: r = $urandom_range(0, 65535);
        endcase
        q = make_req(edge_coord(), edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                     edge_coord(), edge_coord(), edge_coord(), edge_coord(), r);
      end
    endcase
    return q;
  endfunction

  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left = burst_left - 1;
      return 0;
    end
    case ($urandom_range(0, 19))
      0: begin
        burst_left = $urandom_range(20, 60);
        return 0;
      end
      1: return $urandom_range(10, 40);
      2, 3, 4, 5, 6, 7: return $urandom_range(1, 3);
      default: return 0;
    endcase
  endfunction

  task automatic report_bad(input string why, input bit exp_v, input logic got_v);
    if (mismatches < 10) begin
      $display("%0t: %s: expected hit=%0b, got hit=%0b", $realtime, why, exp_v, got_v);
    end
    mismatches++;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (idle_left > 0) begin
        start <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pending.size() > 0) begin
        cur_req <= pending.pop_front();
        start <= 1'b1;
        idle_left <= next_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) begin
        if (hit_queue.size() == 0) begin
          report_bad("result with no request outstanding", 1'b0, hit);
        end else begin
          want = hit_queue.pop_front();
          if (hit !== want) report_bad("hit mismatch", want, hit);
        end
      end
      if (start && busy === 1'b0) hit_queue.push_back(surface_hit(cur_req));
    end
    taken <= !rst && start && busy === 1'b0;
  end

  initial begin
    pending.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(make_req(3, 4, 0, 3, 4, 0, 0, 0, 0, 5));
    pending.push_back(make_req(3, 4, 0, 3, 4, 0, 0, 0, 0, 4));
    pending.push_back(make_req(-10, 5, 0, 10, 5, 0, 0, 0, 0, 5));
    pending.push_back(make_req(-10, 5, 0, 10, 5, 0, 0, 0, 0, 4));
    pending.push_back(make_req(5, 0, 0, 20, 0, 0, 0, 0, 0, 5));
    pending.push_back(make_req(-20, 0, 0, -5, 0, 0, 0, 0, 0, 5));
    pending.push_back(make_req(-20, 0, 0, -6, 0, 0, 0, 0, 0, 5));
    pending.push_back(make_req(-1, 0, 0, 1, 0, 0, 0, 0, 0, 5));
    pending.push_back(make_req(0, 0, 0, 100, 0, 0, 0, 0, 0, 5));
    pending.push_back(make_req(-100, 0, 0, 100, 0, 0, 0, 0, 0, 5));
    pending.push_back(make_req(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0, 65535));
    pending.push_back(make_req(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0, 0));
    pending.push_back(make_req(-32768, -32768, -32768, -32768, -32768, -32768,
                               32767, 32767, 32767, 65535));
    pending.push_back(make_req(32767, 32767, 32767, -32768, -32768, -32768,
                               -32768, 32767, -32768, 65535));
    pending.push_back(make_req(-32768, 0, 0, 32767, 0, 0, 0, 0, 0, 32768));
    pending.push_back(make_req(32767, -32768, 32767, -32768, 32767, -32768, 0, 0, 0, 1));
    pending.push_back(make_req(32767, 32767, 32767, 32767, 32767, 32767,
                               -32768, -32768, -32768, 65535));
    pending.push_back(make_req(-32768, 32767, -32768, 32767, -32768, 32767,
                               -32768, 32767, -32768, 0));
    for (int i = 0; i < RANDOM_ITEMS; i++) pending.push_back(random_req());

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending.size() != 0 || start || hit_queue.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
